// ----- src/oas_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the overlap-add synthesis unit.
// No dependencies; imported by every module of the block.
package oas_pkg;

  // Widths of the configuration registers.
  localparam int FRAME_W = 11;
  localparam int HOP_W   = 10;
  localparam int GAIN_W  = 15;
  localparam int CFG_W   = 15;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd2;

  // Register values after reset.
  localparam logic [FRAME_W-1:0] FRAME_RESET = 11'd1024;
  localparam logic [HOP_W-1:0]   HOP_RESET   = 10'd256;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 15'd8192;

  // Gain is unsigned Q1.14; products are rounded half up to Q1.15.
  localparam int FRAC_BITS  = 14;
  localparam int ROUND_BIAS = 8192;

  // Default build parameters.
  localparam int DEF_MAX_FRAME   = 1024;
  localparam int DEF_SAMPLE_BITS = 16;

endpackage

// ----- src/oas_store.sv -----
`timescale 1ns / 1ps
// Overlap store: single write port, single read port, registered read data.
// Uses oas_pkg for its default parameter values.
module oas_store
  import oas_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_FRAME,
  parameter int WIDTH = DEF_SAMPLE_BITS,
  parameter int AW    = $clog2(DEF_MAX_FRAME)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/oas_mac.sv -----
`timescale 1ns / 1ps
// Scale-and-accumulate datapath: sample times Q1.14 gain, rounded to Q1.15,
// added to the overlap value and saturated. Depends on oas_pkg.
module oas_mac
  import oas_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic        [GAIN_W-1:0]      gain,
  input  logic signed [SAMPLE_BITS-1:0] overlap,
  output logic signed [SAMPLE_BITS-1:0] result
);

  localparam int PW = SAMPLE_BITS + GAIN_W + 1;
  localparam int QW = PW - FRAC_BITS;
  localparam int SW = QW + 1;
  localparam logic signed [PW-1:0] BIAS = PW'(ROUND_BIAS);

  logic signed [GAIN_W:0]  gain_s;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    rounded;
  logic signed [QW-1:0]    scaled;
  logic signed [SW-1:0]    sum;
  logic                    ovf;

  assign gain_s  = $signed({1'b0, gain});
  assign prod    = PW'(sample) * PW'(gain_s);
  assign rounded = prod + BIAS;
  // Dropping the low bits of the two's complement word is a floor.
  assign scaled  = $signed(rounded[PW-1:FRAC_BITS]);
  assign sum     = SW'(scaled) + SW'(overlap);

  // The sum fits when all bits above the sample's sign bit agree with it.
  assign ovf = !((&sum[SW-1:SAMPLE_BITS-1]) || !(|sum[SW-1:SAMPLE_BITS-1]));

  always_comb begin
    if (!ovf) begin
      result = sum[SAMPLE_BITS-1:0];
    end else if (sum[SW-1]) begin
      result = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      result = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

// ----- src/overlap_add_synthesis_unit.sv -----
`timescale 1ns / 1ps
// Overlap-add resynthesis unit. Depends on oas_pkg, oas_store and oas_mac.
//
// Samples of each synthesized frame enter on in_sample/in_valid/in_ready in
// ascending frame order. Each is scaled by gain (Q1.14). The first hop_length
// samples of a frame leave on out_sample/out_valid/out_ready as the stored
// overlap plus the scaled sample, out_last marking the final one; the rest
// are summed into the overlap store for the following frames.
// Configuration (frame_length, hop_length, gain) is written through
// cfg_write/cfg_index/cfg_data and must only change while the unit is idle.
//
// A beat is taken every cycle while in_ready is high. A result passes the
// compute stage, then the output register; the store read is issued at
// acceptance; multiply-add and store write-back happen in the next cycle.
// After reset the overlap store is zeroed one entry per cycle, over all
// MAX_FRAME entries; in_ready stays low during that sweep.
// If the receiver stalls, one result waits in the output register and one
// beat more is held in the compute stage; further input is then refused.
// Beats that only update the store never wait on the receiver.
module overlap_add_synthesis_unit
  import oas_pkg::*;
#(
  parameter int MAX_FRAME   = DEF_MAX_FRAME,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample,
  output logic                          out_last
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int CW = (AW + 1 > FRAME_W) ? AW + 1 : FRAME_W;
  localparam logic [CW-1:0] FRAME_MAX = CW'(MAX_FRAME);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FRAME - 1);

  // Configuration registers.
  logic [FRAME_W-1:0] frame_length;
  logic [HOP_W-1:0]   hop_length;
  logic [GAIN_W-1:0]  gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= FRAME_RESET;
      hop_length   <= HOP_RESET;
      gain         <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME: frame_length <= cfg_data[FRAME_W-1:0];
        REG_HOP:   hop_length   <= cfg_data[HOP_W-1:0];
        REG_GAIN:  gain         <= cfg_data[GAIN_W-1:0];
        default:   ;
      endcase
    end
  end

  // Effective frame and hop after clamping.
  logic [CW-1:0] frame_raw, frame_eff, hop_raw, hop_eff;

  always_comb begin
    frame_raw = CW'(frame_length);
    hop_raw   = CW'(hop_length);
    if (frame_raw < CW'(2)) begin
      frame_eff = CW'(2);
    end else if (frame_raw > FRAME_MAX) begin
      frame_eff = FRAME_MAX;
    end else begin
      frame_eff = frame_raw;
    end
    if (hop_raw == '0) begin
      hop_eff = CW'(1);
    end else if (hop_raw >= frame_eff) begin
      hop_eff = frame_eff - CW'(1);
    end else begin
      hop_eff = hop_raw;
    end
  end

  // Store clearing sweep after reset.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // Frame position and per-beat decode at acceptance.
  logic [AW-1:0] pos, pos_next;
  logic [CW-1:0] pos_x, idx, idx_inc;
  logic          acc_emit, acc_last, acc_keep;
  logic [AW-1:0] acc_wr_addr;
  logic          accept;

  always_comb begin
    pos_x = CW'(pos);
    // A position left beyond a shortened frame restarts the frame.
    idx   = (pos_x >= frame_eff) ? '0 : pos_x;
    idx_inc = idx + CW'(1);
    pos_next = (idx_inc >= frame_eff) ? '0 : idx_inc[AW-1:0];
    acc_emit = idx < hop_eff;
    acc_last = idx == (hop_eff - CW'(1));
    acc_keep = idx < (frame_eff - hop_eff);
    acc_wr_addr = AW'(idx - hop_eff);
  end

  // Compute stage.
  logic                          s1_valid;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_emit, s1_last, s1_keep;
  logic [AW-1:0]                 s1_wr_addr;
  logic                          s1_fwd;
  logic [SAMPLE_BITS-1:0]        s1_fwd_data;
  logic                          s1_go;

  // Store port signals.
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [SAMPLE_BITS-1:0] mem_wd;
  logic [SAMPLE_BITS-1:0] mem_rd;
  logic signed [SAMPLE_BITS-1:0] mac_overlap, mac_result;

  assign s1_go    = s1_valid && (!s1_emit || !out_valid || out_ready);
  assign in_ready = !clearing && (!s1_valid || s1_go);
  assign accept   = in_valid && in_ready;

  assign mem_we = clearing || (s1_go && !s1_emit);
  assign mem_wa = clearing ? clr_addr : s1_wr_addr;
  assign mem_wd = clearing ? '0 : mac_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos <= pos_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // A write landing on the address being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample   <= in_sample;
      s1_emit     <= acc_emit;
      s1_last     <= acc_last;
      s1_keep     <= acc_keep || acc_emit;
      s1_wr_addr  <= acc_wr_addr;
      s1_fwd      <= mem_we && (mem_wa == idx[AW-1:0]);
      s1_fwd_data <= mem_wd;
    end
  end

  oas_store #(
    .DEPTH (MAX_FRAME),
    .WIDTH (SAMPLE_BITS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd),
    .rd_en   (accept),
    .rd_addr (idx[AW-1:0]),
    .rd_data (mem_rd)
  );

  // Overlap past frame minus hop is not part of the next frame's tail.
  always_comb begin
    if (!s1_keep) begin
      mac_overlap = '0;
    end else if (s1_fwd) begin
      mac_overlap = $signed(s1_fwd_data);
    end else begin
      mac_overlap = $signed(mem_rd);
    end
  end

  oas_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .sample  (s1_sample),
    .gain    (gain),
    .overlap (mac_overlap),
    .result  (mac_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_emit) begin
      out_sample <= mac_result;
      out_last   <= s1_last;
    end
  end

  // Checks.
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input accepted during store clear");

  a_stage_empty_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid)
    else $error("compute stage busy during store clear");

  a_only_emit_stalls: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> (s1_emit && out_valid && !out_ready))
    else $error("compute stage stalled without a blocked result");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_sample) && $stable(s1_last)))
    else $error("stalled compute stage lost its beat");

endmodule
